### hdl/cfl_pkg.sv
// Shared types and constants of the circular free-list engine.
// No dependencies; imported by the sequencer and the top level.
package cfl_pkg;

	// Field widths of the stream items
	localparam int IDX_FIELD_W = 10;
	localparam int COUNT_W     = 11;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 24;

	// Count saturates at its field maximum
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Command codes (carried in s_tuser)
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// Status codes (carried in m_tuser)
	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_ACCESS,
		S_LINK,
		S_FINISH
	} cfl_state_t;

endpackage : cfl_pkg

### hdl/cfl_link_ram.sv
// Link memory: one write port and one registered read port.
// Read returns the old contents when the same entry is written in that cycle.
// No package dependencies.
module cfl_link_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read old data, then write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule : cfl_link_ram

### hdl/cfl_ctrl.sv
// Sequencer of the free-list engine: index reduction, link memory accesses,
// head and count registers, and the result register.
// Depends on cfl_pkg.
module cfl_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input item
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_cmd,
	input  logic [cfl_pkg::IDX_FIELD_W-1:0] in_idx,
	// result item
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           out_status,
	output logic [cfl_pkg::IDX_FIELD_W-1:0] out_head,
	output logic [cfl_pkg::COUNT_W-1:0]     out_count,
	output logic                           out_empty,
	// next-link memory
	output logic                           nxt_we,
	output logic [$clog2(DEPTH)-1:0]       nxt_waddr,
	output logic [$clog2(DEPTH)-1:0]       nxt_wdata,
	output logic [$clog2(DEPTH)-1:0]       nxt_raddr,
	input  logic [$clog2(DEPTH)-1:0]       nxt_rdata,
	// previous-link memory
	output logic                           prv_we,
	output logic [$clog2(DEPTH)-1:0]       prv_waddr,
	output logic [$clog2(DEPTH)-1:0]       prv_wdata,
	output logic [$clog2(DEPTH)-1:0]       prv_raddr,
	input  logic [$clog2(DEPTH)-1:0]       prv_rdata
);

	import cfl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [IDX_FIELD_W:0] DEPTH_W = (IDX_FIELD_W+1)'(DEPTH);

	cfl_state_t state_q, state_d;

	logic                   cmd_q;
	logic [IDX_FIELD_W-1:0] idx_q, idx_d;
	logic [AW-1:0]          head_q, head_d;
	logic [COUNT_W-1:0]     count_q, count_d;
	logic                   err_q, err_d;
	logic                   load_out;

	logic [IDX_FIELD_W:0]   sub_diff;
	logic                   in_ge, idx_ge;
	logic [AW-1:0]          blk;

	// Shared compare and subtract unit for the modulo reduction; the input index has its own compare
	assign sub_diff = {1'b0, idx_q} - DEPTH_W;
	assign idx_ge   = !sub_diff[IDX_FIELD_W];
	assign in_ge    = {1'b0, in_idx} >= DEPTH_W;
	assign blk      = idx_q[AW-1:0];

	// State register and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		err_q <= err_d;
		if (in_valid && in_ready) begin
			cmd_q <= in_cmd;
		end
	end

	// Result register: hold until the receiver takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status <= err_q;
			out_head   <= IDX_FIELD_W'(head_q);
			out_count  <= count_q;
			out_empty  <= (count_q == '0);
		end
	end

	// Next state, memory accesses and register updates
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		head_d    = head_q;
		count_d   = count_q;
		err_d     = err_q;
		load_out  = 1'b0;
		in_ready  = 1'b0;
		nxt_we    = 1'b0;
		nxt_waddr = blk;
		nxt_wdata = head_q;
		nxt_raddr = blk;
		prv_we    = 1'b0;
		prv_waddr = head_q;
		prv_wdata = blk;
		prv_raddr = blk;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					idx_d   = in_idx;
					err_d   = STATUS_DONE;
					state_d = in_ge ? S_REDUCE : S_ACCESS;
				end
			end

			S_REDUCE: begin
				// Subtract the depth until the index fits
				if (idx_ge) begin
					idx_d = sub_diff[IDX_FIELD_W-1:0];
				end else begin
					state_d = S_ACCESS;
				end
			end

			S_ACCESS: begin
				state_d = S_FINISH;
				if (cmd_q == CMD_INSERT) begin
					if (count_q == '0) begin
						// First block links to itself
						nxt_we    = 1'b1;
						nxt_waddr = blk;
						nxt_wdata = blk;
						prv_we    = 1'b1;
						prv_waddr = blk;
						prv_wdata = blk;
						head_d    = blk;
						count_d   = COUNT_W'(1);
					end else begin
						// Fetch the tail; link block to the old head
						prv_raddr = head_q;
						nxt_we    = 1'b1;
						nxt_waddr = blk;
						nxt_wdata = head_q;
						prv_we    = 1'b1;
						prv_waddr = head_q;
						prv_wdata = blk;
						state_d   = S_LINK;
					end
				end else begin
					if (count_q == '0) begin
						err_d = STATUS_EMPTY;
					end else if (count_q == COUNT_W'(1)) begin
						// Last entry: drop the whole list
						head_d  = '0;
						count_d = '0;
					end else begin
						// Fetch both neighbours of the block
						prv_raddr = blk;
						nxt_raddr = blk;
						state_d   = S_LINK;
					end
				end
			end

			S_LINK: begin
				state_d = S_FINISH;
				if (cmd_q == CMD_INSERT) begin
					// Close the ring from the tail to the new head
					nxt_we    = 1'b1;
					nxt_waddr = prv_rdata;
					nxt_wdata = blk;
					prv_we    = 1'b1;
					prv_waddr = blk;
					prv_wdata = prv_rdata;
					head_d    = blk;
					if (count_q != COUNT_MAX) begin
						count_d = count_q + COUNT_W'(1);
					end
				end else begin
					// Bridge predecessor and successor
					prv_we    = 1'b1;
					prv_waddr = nxt_rdata;
					prv_wdata = prv_rdata;
					nxt_we    = 1'b1;
					nxt_waddr = prv_rdata;
					nxt_wdata = nxt_rdata;
					if (blk == head_q) begin
						head_d = nxt_rdata;
					end
					count_d = count_q - COUNT_W'(1);
				end
			end

			S_FINISH: begin
				// Wait for a free result slot
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule : cfl_ctrl

### hdl/circular_free_list_engine_top.sv
// Top level of the circular free-list engine: stream ports, two link
// memories and the sequencer. Depends on cfl_pkg, cfl_link_ram, cfl_ctrl.
//
// Usage:
//   Slave channel s_*: one command per transfer. s_tuser is the command
//   (insert at head or delete), s_tdata[9:0] the block index; an index at or
//   above the number of blocks is reduced modulo that number.
//   Master channel m_*: one result per command: m_tuser is the status (set
//   when a delete meets an empty list), m_tdata carries the head index, the
//   entry count and the empty flag after the command.
//   Timing: a command is taken in the idle state, then passes the access state,
//   the link state when links are spliced (insert into a non-empty list, delete
//   from two or more) and the finish state, which loads the result register.
//   The next command is taken back in the idle state, one command at a time.
//   Where the index needs reducing, the reduce state subtracts the depth until a
//   final compare finds it in range (none at 1024 blocks). An insert reads the
//   tail and then writes four links, two per memory, in the access and link states.
//   Reset clears the head and the count; link memories are not cleared.
//   Stall: a result waits in the output register while m_tready is low; the
//   next command may already be taken and runs up to its result, then holds.
module circular_free_list_engine_top #(
	parameter int NUM_BLOCKS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cfl_pkg::S_TDATA_W-1:0]  s_tdata,  // [9:0] block_index, [15:10] zero
	input  logic                           s_tuser,  // [0] command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cfl_pkg::M_TDATA_W-1:0]  m_tdata,  // [9:0] head_index, [20:10] entry_count,
	                                                 // [21] list_empty, [23:22] zero
	output logic                           m_tuser   // [0] status
);

	import cfl_pkg::*;

	// Only indices below the field range are ever reached
	localparam int DEPTH = (NUM_BLOCKS < (1 << IDX_FIELD_W)) ? NUM_BLOCKS
	                                                        : (1 << IDX_FIELD_W);
	localparam int AW    = $clog2(DEPTH);

	logic                   nxt_we, prv_we;
	logic [AW-1:0]          nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
	logic [AW-1:0]          prv_waddr, prv_wdata, prv_raddr, prv_rdata;
	logic [IDX_FIELD_W-1:0] head_out;
	logic [COUNT_W-1:0]     count_out;
	logic                   empty_out;

	// Pack the result fields, lowest first
	assign m_tdata = {{(M_TDATA_W - IDX_FIELD_W - COUNT_W - 1){1'b0}},
	                  empty_out, count_out, head_out};

	cfl_link_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (nxt_raddr),
		.rdata (nxt_rdata)
	);

	cfl_link_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_prev_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (prv_raddr),
		.rdata (prv_rdata)
	);

	cfl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_idx     (s_tdata[IDX_FIELD_W-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_head   (head_out),
		.out_count  (count_out),
		.out_empty  (empty_out),
		.nxt_we     (nxt_we),
		.nxt_waddr  (nxt_waddr),
		.nxt_wdata  (nxt_wdata),
		.nxt_raddr  (nxt_raddr),
		.nxt_rdata  (nxt_rdata),
		.prv_we     (prv_we),
		.prv_waddr  (prv_waddr),
		.prv_wdata  (prv_wdata),
		.prv_raddr  (prv_raddr),
		.prv_rdata  (prv_rdata)
	);

endmodule : circular_free_list_engine_top
